@@ rtl/csvp_pkg.sv @@
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants of the csv decimal field parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 6;
  localparam int MANT_W     = 32;
  localparam int FRAC_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int FLEN_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUES       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELD_LENGTH = 1'b1;

  // register reset values
  localparam logic [IDX_W-1:0]  MAX_VALUES_RST       = 6'd13;
  localparam logic [FLEN_W-1:0] MAX_FIELD_LENGTH_RST = 10'd256;

  // result kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // packet status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_TOO_MANY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_COMMAND  = 2'd3;

  // characters
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 10'd1023;

  typedef struct packed {
    logic [IDX_W-1:0]  max_values;
    logic [FLEN_W-1:0] max_field_length;
  } cfg_t;

  typedef struct packed {
    logic                result_kind;
    logic [IDX_W-1:0]    field_index;
    logic                negative;
    logic [MANT_W-1:0]   mantissa;
    logic [FRAC_W-1:0]   fraction_digits;
    logic                mantissa_overflow;
    logic [STATUS_W-1:0] packet_status;
    logic [IDX_W-1:0]    value_count;
    logic                last_result;
  } result_t;

  // words produced by one input word, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } core_out_t;

endpackage

@@ rtl/csvp_core.sv @@
// ----------------------------------------------------------------------------
// csvp_core
// Field and packet state with the per-byte parse logic.
// ----------------------------------------------------------------------------
module csvp_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [csvp_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              end_of_packet,
  input  logic                              advance,
  input  csvp_pkg::cfg_t                    cfg,
  output csvp_pkg::core_out_t               core_out
);

  logic [csvp_pkg::FLEN_W-1:0]   field_byte_count, field_byte_count_next;
  logic [csvp_pkg::MANT_W-1:0]   mantissa_acc, mantissa_acc_next;
  logic [csvp_pkg::FRAC_W-1:0]   frac_count, frac_count_next;
  logic                          point_flag, point_flag_next;
  logic                          sign_flag, sign_flag_next;
  logic                          overflow_flag, overflow_flag_next;
  logic [csvp_pkg::IDX_W-1:0]    values_seen, values_seen_next;
  logic                          packet_start, packet_start_next;
  logic [csvp_pkg::STATUS_W-1:0] error_code, error_code_next;

  logic                          is_digit;
  logic [3:0]                    digit;
  logic [csvp_pkg::MANT_W+3:0]   times_ten;
  logic                          value_emit;
  csvp_pkg::result_t             value_res;
  csvp_pkg::result_t             status_res;

  assign is_digit = (data_byte >= csvp_pkg::CH_ZERO) && (data_byte <= csvp_pkg::CH_NINE);
  assign digit    = 4'(data_byte - csvp_pkg::CH_ZERO);
  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
  assign times_ten = {1'b0, mantissa_acc, 3'b000} + {3'b000, mantissa_acc, 1'b0}
                   + {32'd0, digit};

  always_comb begin
    field_byte_count_next = field_byte_count;
    mantissa_acc_next     = mantissa_acc;
    frac_count_next       = frac_count;
    point_flag_next       = point_flag;
    sign_flag_next        = sign_flag;
    overflow_flag_next    = overflow_flag;
    values_seen_next      = values_seen;
    packet_start_next     = 1'b0;
    error_code_next       = error_code;
    value_emit            = 1'b0;

    if (packet_start && (data_byte == csvp_pkg::CH_COLON)) begin
      error_code_next = csvp_pkg::STAT_COMMAND;
    end else if (error_code == csvp_pkg::STAT_OK) begin
      if (field_byte_count >= cfg.max_field_length) begin
        error_code_next = csvp_pkg::STAT_TOO_LONG;
      end else if (data_byte == csvp_pkg::CH_COMMA) begin
        value_emit            = 1'b1;
        values_seen_next      = values_seen + 1'b1;
        field_byte_count_next = '0;
        mantissa_acc_next     = '0;
        frac_count_next       = '0;
        point_flag_next       = 1'b0;
        sign_flag_next        = 1'b0;
        overflow_flag_next    = 1'b0;
        if (values_seen_next >= cfg.max_values) begin
          error_code_next = csvp_pkg::STAT_TOO_MANY;
        end
      end else begin
        if ((field_byte_count == '0) && (data_byte == csvp_pkg::CH_MINUS)) begin
          sign_flag_next = 1'b1;
        end else if (data_byte == csvp_pkg::CH_POINT) begin
          point_flag_next = 1'b1;
        end else if (is_digit) begin
          if (times_ten[csvp_pkg::MANT_W+3:csvp_pkg::MANT_W] != 4'd0) begin
            mantissa_acc_next  = '1;
            overflow_flag_next = 1'b1;
          end else begin
            mantissa_acc_next = times_ten[csvp_pkg::MANT_W-1:0];
          end
          if (point_flag && (frac_count < csvp_pkg::FRAC_MAX)) begin
            frac_count_next = frac_count + 1'b1;
          end
        end
        field_byte_count_next = field_byte_count + 1'b1;
      end
    end

    // result words, built before the packet clear below
    value_res                   = '0;
    value_res.result_kind       = csvp_pkg::KIND_VALUE;
    value_res.field_index       = values_seen;
    value_res.negative          = sign_flag;
    value_res.mantissa          = mantissa_acc;
    value_res.fraction_digits   = frac_count;
    value_res.mantissa_overflow = overflow_flag;
    value_res.last_result       = !end_of_packet;

    status_res               = '0;
    status_res.result_kind   = csvp_pkg::KIND_STATUS;
    status_res.packet_status = error_code_next;
    status_res.value_count   = values_seen_next;
    status_res.last_result   = 1'b1;

    if (end_of_packet) begin
      field_byte_count_next = '0;
      mantissa_acc_next     = '0;
      frac_count_next       = '0;
      point_flag_next       = 1'b0;
      sign_flag_next        = 1'b0;
      overflow_flag_next    = 1'b0;
      values_seen_next      = '0;
      packet_start_next     = 1'b1;
      error_code_next       = csvp_pkg::STAT_OK;
    end

    core_out = '0;
    if (value_emit && end_of_packet) begin
      core_out.count = 2'd2;
      core_out.res_a = value_res;
      core_out.res_b = status_res;
    end else if (value_emit) begin
      core_out.count = 2'd1;
      core_out.res_a = value_res;
    end else if (end_of_packet) begin
      core_out.count = 2'd1;
      core_out.res_a = status_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_byte_count <= '0;
      mantissa_acc     <= '0;
      frac_count       <= '0;
      point_flag       <= 1'b0;
      sign_flag        <= 1'b0;
      overflow_flag    <= 1'b0;
      values_seen      <= '0;
      packet_start     <= 1'b1;
      error_code       <= csvp_pkg::STAT_OK;
    end else if (advance) begin
      field_byte_count <= field_byte_count_next;
      mantissa_acc     <= mantissa_acc_next;
      frac_count       <= frac_count_next;
      point_flag       <= point_flag_next;
      sign_flag        <= sign_flag_next;
      overflow_flag    <= overflow_flag_next;
      values_seen      <= values_seen_next;
      packet_start     <= packet_start_next;
      error_code       <= error_code_next;
    end
  end

  // an overflow flag always comes with a saturated mantissa
  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    (overflow_flag |-> (mantissa_acc == '1)))
    else $error("overflow flag without saturated mantissa");

  // digits after the point only count once a point was seen
  a_frac_point: assert property (@(posedge clk) disable iff (rst)
    ((frac_count != '0) |-> point_flag))
    else $error("fraction digits without a point");

  // the status word is always the last word of its input
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    ((core_out.count == 2'd2) |-> (core_out.res_b.result_kind == csvp_pkg::KIND_STATUS
                                   && !core_out.res_a.last_result)))
    else $error("status word not last");

endmodule

@@ rtl/csvp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// csvp_out_fifo
// Small result queue taking up to two words per cycle while it has room, one out per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module csvp_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  csvp_pkg::result_t push_a,
  input  csvp_pkg::result_t push_b,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output csvp_pkg::result_t out_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csvp_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr, wr_ptr_b;
  logic [CNT_W-1:0]  count;
  logic              pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_b  = ptr_inc(wr_ptr);
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push_count)
        2'd1:    wr_ptr <= wr_ptr_b;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr_b);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(DEPTH)))
    else $error("result queue over depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ((push_count != 2'd0) |-> room2))
    else $error("push without room for two words");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ((push_count == 2'd0) && !pop |=> $stable(count)))
    else $error("queue count moved without push or pop");

endmodule

@@ rtl/csv_decimal_field_parser_unit.sv @@
// ----------------------------------------------------------------------------
// csv_decimal_field_parser_unit
// Byte-wise csv packet parser giving decimal values and a packet status.
// ----------------------------------------------------------------------------
// Packets arrive one byte per input word, end_of_packet set on the last byte.
// A comma in a packet with no error status closes a field and yields a value
// word (sign, saturating 32-bit decimal mantissa, digits after the point); the
// last byte of a packet also yields one status word (ok, too many values,
// field too long, command packet). A field left open at packet end gives no
// word. An input word is registered on acceptance and parsed into a four-entry
// result queue once it has room for two words; a byte is taken every cycle as
// long as the queue has that room, so the sustained rate is one byte per cycle
// while the output side keeps up. The output delivers one word per cycle while
// out_ready is high. Registers are written through the cfg port (index 0
// max_values, 1 max_field_length); the user must do so only while the block is
// idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module csv_decimal_field_parser_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csvp_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [csvp_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                end_of_packet,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_kind,
  output logic [csvp_pkg::IDX_W-1:0]          field_index,
  output logic                                negative,
  output logic [csvp_pkg::MANT_W-1:0]         mantissa,
  output logic [csvp_pkg::FRAC_W-1:0]         fraction_digits,
  output logic                                mantissa_overflow,
  output logic [csvp_pkg::STATUS_W-1:0]       packet_status,
  output logic [csvp_pkg::IDX_W-1:0]          value_count,
  output logic                                last_result
);

  csvp_pkg::cfg_t             cfg;
  logic                       in_full;
  logic [csvp_pkg::BYTE_W-1:0] in_byte;
  logic                       in_eop;
  logic                       advance;
  logic                       room2;
  csvp_pkg::core_out_t        core_out;
  csvp_pkg::result_t          out_word;
  logic                       in_accept;

  // config registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_values       <= csvp_pkg::MAX_VALUES_RST;
      cfg.max_field_length <= csvp_pkg::MAX_FIELD_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csvp_pkg::REG_MAX_VALUES:
          cfg.max_values <= cfg_data[csvp_pkg::IDX_W-1:0];
        csvp_pkg::REG_MAX_FIELD_LENGTH:
          cfg.max_field_length <= cfg_data[csvp_pkg::FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: the held byte is parsed once the queue can take two words
  assign advance   = in_full && room2;
  assign in_ready  = !in_full || advance;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte <= data_byte;
      in_eop  <= end_of_packet;
    end
  end

  // parse state and per-byte logic
  csvp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (in_byte),
    .end_of_packet (in_eop),
    .advance       (advance),
    .cfg           (cfg),
    .core_out      (core_out)
  );

  // result queue, one word out per cycle while out_ready is high
  csvp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (advance ? core_out.count : 2'd0),
    .push_a     (core_out.res_a),
    .push_b     (core_out.res_b),
    .room2      (room2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  assign result_kind       = out_word.result_kind;
  assign field_index       = out_word.field_index;
  assign negative          = out_word.negative;
  assign mantissa          = out_word.mantissa;
  assign fraction_digits   = out_word.fraction_digits;
  assign mantissa_overflow = out_word.mantissa_overflow;
  assign packet_status     = out_word.packet_status;
  assign value_count       = out_word.value_count;
  assign last_result       = out_word.last_result;

  // a byte with end of packet always yields a status word
  a_eop_status: assert property (@(posedge clk) disable iff (rst)
    ((advance && in_eop) |-> (core_out.count != 2'd0)))
    else $error("end of packet without status word");

  // a held byte that cannot be parsed blocks new input
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    ((in_full && !room2) |-> !in_ready))
    else $error("input taken while held byte is stalled");

  // a stalled held byte keeps its value
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    ((in_full && !advance) |=> ($stable(in_byte) && $stable(in_eop))))
    else $error("held byte changed while stalled");

endmodule
